/* hw/rtl/pat_pkg.sv */
// ----------------------------------------------------------------------------
// pat_pkg
// shared widths, register map, limits and the exponent constant table of the
// progressive accumulate and tonemap block
// ----------------------------------------------------------------------------
package pat_pkg;

  // image and pass limits
  localparam int MAX_WIDTH  = 1280;
  localparam int MAX_HEIGHT = 800;
  localparam int PASS_LIMIT = 1024;
  localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(PIXELS);

  // field widths
  localparam int XW = 11;
  localparam int YW = 10;
  localparam int PW = 10;
  localparam int NW = PW + 1;
  localparam int RW = 24;
  localparam int SW = 34;
  localparam int BW = 8;
  localparam int GW = 15;
  localparam int NCH = 3;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GAMMA  = 2'd2;
  localparam logic [XW-1:0] WIDTH_RST  = XW'(1280);
  localparam logic [YW-1:0] HEIGHT_RST = YW'(800);
  localparam logic [GW-1:0] GAMMA_ONE  = GW'(4096);

  // lane pipeline shape
  localparam int DIV1_STEPS = 8;
  localparam int LOG_STEPS  = 16;
  localparam int DIV2_STEPS = 11;
  localparam int EXP_STEPS  = 16;
  localparam int LANE_LAT   = 2 + DIV1_STEPS + 1 + LOG_STEPS + 1 + DIV2_STEPS + EXP_STEPS + 1;

  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [RW-1:0] rad_t;
  typedef logic [63:0] expc_t [EXP_STEPS+1];

  // integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // c_k = 2^(-2^-k) in q1.30 for k >= 1; c_0 is 1.0
  function automatic expc_t exp_table();
    expc_t t;
    t[0] = 64'd1 << 30;
    t[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= EXP_STEPS; k++) begin
      t[k] = isqrt64(t[k-1] << 30);
    end
    return t;
  endfunction

  localparam expc_t EXP_C = exp_table();

endpackage

/* hw/rtl/progressive_accumulate_tonemap_top.sv */
// ----------------------------------------------------------------------------
// progressive_accumulate_tonemap_top
// per-pixel running radiance sum with averaging and gamma tonemap
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one traced sample a beat (position, pass, rgb
//   radiance); output channel carries one display pixel a beat (position and
//   three bytes). samples outside the image are taken and dropped.
//   the sum memory holds one word per pixel; pass 0 overwrites it, later
//   passes add to it, so a pixel must see pass 0 before any other pass.
//   throughput: one sample a cycle while the output is not stalled, set by the
//   single read and single write port of the sum memory; back-to-back samples
//   to the same pixel are forwarded around the memory.
//   pipeline: one memory read stage, then 56 stages in each channel lane, the
//   last one being the output register.
//   reset clears all valid flags and loads 1280 x 800 and gamma 1.0; the sum
//   memory is not cleared.
//   a stalled output freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module progressive_accumulate_tonemap_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pat_pkg::PADDR_W-1:0] paddr,
  input  logic [pat_pkg::PDATA_W-1:0] pwdata,
  output logic [pat_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // sample input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pat_pkg::XW-1:0]      pixel_x_i,
  input  logic [pat_pkg::YW-1:0]      pixel_y_i,
  input  logic [pat_pkg::PW-1:0]      pass_number_i,
  input  pat_pkg::rad_t               radiance_red_i,
  input  pat_pkg::rad_t               radiance_green_i,
  input  pat_pkg::rad_t               radiance_blue_i,
  // display output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pat_pkg::XW-1:0]      out_x_o,
  output logic [pat_pkg::YW-1:0]      out_y_o,
  output logic [pat_pkg::BW-1:0]      display_red_o,
  output logic [pat_pkg::BW-1:0]      display_green_o,
  output logic [pat_pkg::BW-1:0]      display_blue_o
);
  import pat_pkg::*;

  // configuration registers
  logic [XW-1:0] width_q;
  logic [YW-1:0] height_q;
  logic [GW-1:0] gamma_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      gamma_q  <= GAMMA_ONE;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[XW-1:0];
        REG_HEIGHT: height_q <= pwdata[YW-1:0];
        REG_GAMMA:  gamma_q  <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      REG_GAMMA:  prdata = PDATA_W'(gamma_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline enable and input qualification
  logic          advance, in_range, acc;
  logic [AW-1:0] addr_in;
  rad_t          rad_in [NCH];

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_range   = (pixel_x_i < width_q) && (32'(pixel_x_i) < 32'(MAX_WIDTH)) &&
                      (pixel_y_i < height_q) && (32'(pixel_y_i) < 32'(MAX_HEIGHT)) &&
                      (32'(pass_number_i) < 32'(PASS_LIMIT));
  assign acc        = in_valid_i && advance && in_range;
  assign addr_in    = AW'(pixel_y_i) * AW'(MAX_WIDTH) + AW'(pixel_x_i);
  assign rad_in[0]  = radiance_red_i;
  assign rad_in[1]  = radiance_green_i;
  assign rad_in[2]  = radiance_blue_i;

  // memory read stage
  logic          rd_vld_q, fwd_q;
  logic [XW-1:0] rd_x_q;
  logic [YW-1:0] rd_y_q;
  logic [PW-1:0] rd_pass_q;
  logic [AW-1:0] rd_addr_q;
  rad_t          rd_rad_q  [NCH];
  sum_t          fwd_sum_q [NCH];
  sum_t          new_sum   [NCH];
  logic [NCH*SW-1:0] ram_rdata, ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (advance) begin
      rd_vld_q <= acc;
      fwd_q    <= rd_vld_q && (addr_in == rd_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_sum_q <= new_sum;
      if (acc) begin
        rd_x_q    <= pixel_x_i;
        rd_y_q    <= pixel_y_i;
        rd_pass_q <= pass_number_i;
        rd_addr_q <= addr_in;
        rd_rad_q  <= rad_in;
      end
    end
  end

  pat_ram #(
    .WIDTH(NCH * SW),
    .DEPTH(PIXELS)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (advance && rd_vld_q),
    .waddr_i(rd_addr_q),
    .wdata_i(ram_wdata),
    .re_i   (advance),
    .raddr_i(addr_in),
    .rdata_o(ram_rdata)
  );

  // accumulate with saturation, then one lane per channel
  logic [BW-1:0] lane_byte [NCH];
  logic [NW-1:0] n_cur;
  logic          restart;

  assign n_cur   = NW'(rd_pass_q) + NW'(1);
  assign restart = (rd_pass_q == '0);

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    sum_t               old;
    logic signed [SW:0] tot;
    always_comb begin
      old = fwd_q ? fwd_sum_q[c] : sum_t'(ram_rdata[c*SW +: SW]);
      tot = restart ? (SW+1)'(rd_rad_q[c]) : (SW+1)'(old) + (SW+1)'(rd_rad_q[c]);
      if (tot[SW] != tot[SW-1]) begin
        new_sum[c] = tot[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        new_sum[c] = tot[SW-1:0];
      end
    end
    assign ram_wdata[c*SW +: SW] = new_sum[c];

    pat_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (advance),
      .sum_i  (new_sum[c]),
      .n_i    (n_cur),
      .gamma_i(gamma_q),
      .byte_o (lane_byte[c])
    );
  end

  // position and valid travel beside the lanes
  logic          sl_vld_q [LANE_LAT];
  logic [XW-1:0] sl_x_q   [LANE_LAT];
  logic [YW-1:0] sl_y_q   [LANE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) sl_vld_q[i] <= 1'b0;
    end else if (advance) begin
      sl_vld_q[0] <= rd_vld_q;
      for (int i = 1; i < LANE_LAT; i++) sl_vld_q[i] <= sl_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sl_x_q[0] <= rd_x_q;
      sl_y_q[0] <= rd_y_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        sl_x_q[i] <= sl_x_q[i-1];
        sl_y_q[i] <= sl_y_q[i-1];
      end
    end
  end

  // merge lanes into the output beat
  assign out_valid_o     = sl_vld_q[LANE_LAT-1];
  assign out_x_o         = sl_x_q[LANE_LAT-1];
  assign out_y_o         = sl_y_q[LANE_LAT-1];
  assign display_red_o   = lane_byte[0];
  assign display_green_o = lane_byte[1];
  assign display_blue_o  = lane_byte[2];

  // checks
  a_drop_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_range |=> !rd_vld_q)
    else $error("dropped sample entered the pipeline");

  a_fwd_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q && fwd_q |-> $past(rd_vld_q))
    else $error("forward taken without a preceding sample");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("output beat lost while stalled");

  a_out_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_x_o < width_q) && (out_y_o < height_q))
    else $error("output pixel outside the image");

endmodule

/* hw/rtl/pat_ram.sv */
// ----------------------------------------------------------------------------
// pat_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/pat_lane.sv */
// ----------------------------------------------------------------------------
// pat_lane
// one color channel: mean by pass count, log2, exponent divide by gamma,
// power of two and rounding to a display byte, fully pipelined
// ----------------------------------------------------------------------------
module pat_lane (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  pat_pkg::sum_t          sum_i,
  input  logic [pat_pkg::NW-1:0] n_i,
  input  logic [pat_pkg::GW-1:0] gamma_i,
  output logic [pat_pkg::BW-1:0] byte_o
);
  import pat_pkg::*;

  localparam int DRW = 27;
  localparam int ER  = 37;

  typedef struct packed {
    logic          done;
    logic [BW-1:0] early;
  } side_t;

  logic [GW-1:0] g_eff;
  assign g_eff = (gamma_i == '0) ? GW'(1) : gamma_i;

  // input register
  sum_t          sum_q;
  logic [NW-1:0] n_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_i;
      n_q   <= n_i;
    end
  end

  // sign and saturation check, start of the mean division
  logic [DRW-1:0] drem_q [DIV1_STEPS+1];
  logic [15:0]    dq_q   [DIV1_STEPS+1];
  logic [NW-1:0]  dn_q   [DIV1_STEPS+1];
  side_t          dside_q[DIV1_STEPS+1];
  logic           pos, ovf;

  always_comb begin
    pos = !sum_q[SW-1] && (sum_q != '0);
    ovf = $unsigned(sum_q) >= (SW'(n_q) << 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0]        <= sum_q[DRW-1:0];
      dq_q[0]          <= '0;
      dn_q[0]          <= n_q;
      dside_q[0].done  <= !pos || ovf;
      dside_q[0].early <= (pos && ovf) ? BW'(255) : '0;
    end
  end

  // mean division, two quotient bits a stage
  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    localparam int HI = 15 - 2 * k;
    logic [DRW-1:0] t_a, t_b, r_a, r_b;
    logic           q_a, q_b;
    always_comb begin
      t_a = DRW'(dn_q[k]) << HI;
      t_b = DRW'(dn_q[k]) << (HI - 1);
      q_a = drem_q[k] >= t_a;
      r_a = q_a ? drem_q[k] - t_a : drem_q[k];
      q_b = r_a >= t_b;
      r_b = q_b ? r_a - t_b : r_a;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k+1]  <= r_b;
        dq_q[k+1]    <= dq_q[k] | (16'({q_a, q_b}) << (HI - 1));
        dn_q[k+1]    <= dn_q[k];
        dside_q[k+1] <= dside_q[k];
      end
    end
  end

  // zero mean, linear bypass and normalization
  logic [30:0] lx_q  [LOG_STEPS+1];
  logic [19:0] llg_q [LOG_STEPS+1];
  side_t       lside_q[LOG_STEPS+1];
  logic [15:0] m;
  logic [3:0]  lead;
  logic [24:0] lin;
  side_t       nside;

  always_comb begin
    m    = dq_q[DIV1_STEPS];
    lead = '0;
    for (int b = 0; b < 16; b++) begin
      if (m[b]) lead = 4'(b);
    end
    lin   = (25'(m) * 25'(255) + 25'(32768)) >> 16;
    nside = dside_q[DIV1_STEPS];
    if (!nside.done) begin
      if (m == '0) begin
        nside.done  = 1'b1;
        nside.early = '0;
      end else if (gamma_i == GAMMA_ONE) begin
        nside.done  = 1'b1;
        nside.early = lin[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q[0]    <= 31'(m) << (5'd30 - 5'(lead));
      llg_q[0]   <= {lead, 16'b0};
      lside_q[0] <= nside;
    end
  end

  // log2 fraction by repeated squaring, one bit a stage
  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
    localparam int BIT = 15 - j;
    logic [61:0] sq;
    logic [31:0] t;
    logic [30:0] x_n;
    logic [19:0] lg_n;
    always_comb begin
      sq   = 62'(lx_q[j]) * 62'(lx_q[j]);
      t    = sq[61:30];
      lg_n = llg_q[j];
      if (t[31]) begin
        x_n       = t[31:1];
        lg_n[BIT] = 1'b1;
      end else begin
        x_n = t[30:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lx_q[j+1]    <= x_n;
        llg_q[j+1]   <= lg_n;
        lside_q[j+1] <= lside_q[j];
      end
    end
  end

  // exponent numerator and range check
  logic [ER-1:0] erem_q [DIV2_STEPS+1];
  logic [21:0]   eq_q   [DIV2_STEPS+1];
  side_t         eside_q[DIV2_STEPS+1];
  logic [20:0]   a;
  logic [ER-1:0] num, lim;
  logic          big;
  side_t         aside;

  always_comb begin
    a     = 21'(32'd16 << 16) - 21'(llg_q[LOG_STEPS]);
    num   = (ER'(a) << 12) + ER'(g_eff >> 1);
    lim   = (ER'(g_eff) * ER'(31)) << 16;
    big   = num >= lim;
    aside = lside_q[LOG_STEPS];
    if (!aside.done && big) begin
      aside.done  = 1'b1;
      aside.early = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      erem_q[0]  <= num;
      eq_q[0]    <= '0;
      eside_q[0] <= aside;
    end
  end

  // exponent division by gamma, two quotient bits a stage
  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    localparam int HI = 21 - 2 * k;
    logic [ER-1:0] t_a, t_b, r_a, r_b;
    logic          q_a, q_b;
    always_comb begin
      t_a = ER'(g_eff) << HI;
      t_b = ER'(g_eff) << (HI - 1);
      q_a = erem_q[k] >= t_a;
      r_a = q_a ? erem_q[k] - t_a : erem_q[k];
      q_b = r_a >= t_b;
      r_b = q_b ? r_a - t_b : r_a;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        erem_q[k+1]  <= r_b;
        eq_q[k+1]    <= eq_q[k] | (22'({q_a, q_b}) << (HI - 1));
        eside_q[k+1] <= eside_q[k];
      end
    end
  end

  // power of two from the fraction bits, one constant a stage
  logic [30:0] ey_q   [EXP_STEPS];
  logic [21:0] ee_q   [EXP_STEPS];
  side_t       xside_q[EXP_STEPS];

  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    logic [30:0] y_in;
    logic [21:0] e_in;
    side_t       s_in;
    logic [60:0] prod;
    if (k == 0) begin : g_first
      assign y_in = 31'(EXP_C[0]);
      assign e_in = eq_q[DIV2_STEPS];
      assign s_in = eside_q[DIV2_STEPS];
    end else begin : g_next
      assign y_in = ey_q[k-1];
      assign e_in = ee_q[k-1];
      assign s_in = xside_q[k-1];
    end
    assign prod = 61'(y_in) * 61'(EXP_C[k+1][29:0]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ey_q[k]    <= e_in[15-k] ? prod[60:30] : y_in;
        ee_q[k]    <= e_in;
        xside_q[k] <= s_in;
      end
    end
  end

  // integer shift, scale to a byte and pick the result
  logic [30:0] y_sh;
  logic [38:0] scaled;
  side_t       fside;

  always_comb begin
    y_sh   = ey_q[EXP_STEPS-1] >> ee_q[EXP_STEPS-1][21:16];
    scaled = (39'(y_sh) * 39'(255) + (39'd1 << 29)) >> 30;
    fside  = xside_q[EXP_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_o <= fside.done ? fside.early : scaled[BW-1:0];
    end
  end

endmodule
